>>> hw/rtl/sct_pkg.sv
// shared types, constants and helpers of the scope capture and trigger block
// no dependencies
package sct_pkg;

  localparam int FrameColumnsDefault = 99;
  localparam int DcRunLengthDefault  = 500;
  localparam int CrossTimeoutDefault = 1000;

  localparam int SampleW = 8;
  localparam int ColumnW = 7;
  localparam int RowW    = 6;
  localparam int OffsetW = 7;
  localparam int RunW    = 9;
  localparam int WaitW   = 10;

  localparam logic [SampleW-1:0] TriggerReset = 8'd2;
  localparam logic [SampleW-1:0] MinReset     = 8'hff;
  localparam logic [SampleW-1:0] MaxReset     = 8'h00;
  localparam logic [RunW-1:0]    RunMax       = 9'd511;
  localparam logic [WaitW-1:0]   WaitMax      = 10'd1023;
  localparam logic [RowW-1:0]    RowMax       = 6'd63;

  typedef logic [SampleW-1:0] sample_t;

  // result of one processed beat, handed from the control path to the output stage
  typedef struct packed {
    logic               produce;
    logic [ColumnW-1:0] column;
    logic               frame_last;
    sample_t            trigger_level;
  } sct_result_t;

  // x / 5 for x below 512 by reciprocal multiply
  function automatic logic [7:0] div5(input logic [8:0] x);
    logic [17:0] prod;
    prod = 18'(x) * 18'd205;
    return prod[17:10];
  endfunction

endpackage

>>> hw/rtl/sct_if.sv
// valid/ready stream interfaces for sample beats in and display point beats out
// depends on sct_pkg
interface sct_sample_if;
  import sct_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sct_point_if;
  import sct_pkg::*;
  logic               valid;
  logic               ready;
  logic [ColumnW-1:0] column;
  logic [RowW-1:0]    row;
  logic               frame_last;
  sample_t            trigger_level;
  modport source (output valid, output column, output row, output frame_last,
                  output trigger_level, input ready);
  modport sink (input valid, input column, input row, input frame_last,
                input trigger_level, output ready);
endinterface

>>> hw/rtl/sct_row_map.sv
// maps one sample to its display row with the vertical offset applied
// depends on sct_pkg
module sct_row_map
  import sct_pkg::*;
(
  input  sample_t                    sample,
  input  logic signed [OffsetW-1:0]  vertical_offset,
  output logic        [RowW-1:0]     row
);

  logic        [7:0] base;
  logic signed [9:0] pos;

  always_comb begin
    base = (sample == '0) ? 8'd2 : 8'(div5(9'(sample) + 9'd5) + 8'd2);
    pos  = $signed({2'b00, base}) + 10'sd5 + 10'(vertical_offset);
    if (pos < 0 || pos > $signed({4'b0000, RowMax})) begin
      row = '0;
    end else begin
      row = pos[RowW-1:0];
    end
  end

endmodule

>>> hw/rtl/sct_ctrl.sv
// capture / trigger search sequencer: frame limits, trigger level, ac/dc search
// depends on sct_pkg
module sct_ctrl
  import sct_pkg::*;
#(
  parameter int FRAME_COLUMNS = FrameColumnsDefault,
  parameter int DC_RUN_LENGTH = DcRunLengthDefault,
  parameter int CROSS_TIMEOUT = CrossTimeoutDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  sample_t     sample,
  output sct_result_t result
);

  localparam logic [1:0] PhCapture = 2'd0;
  localparam logic [1:0] PhSearch  = 2'd1;
  localparam logic [1:0] PhFall    = 2'd2;
  localparam logic [1:0] PhRise    = 2'd3;

  localparam logic [ColumnW-1:0] ColTop  = ColumnW'(FRAME_COLUMNS);
  localparam logic [RunW-1:0]    RunLim  = RunW'(DC_RUN_LENGTH);
  localparam logic [WaitW-1:0]   WaitLim = WaitW'(CROSS_TIMEOUT);

  logic [1:0]         phase, phase_next;
  logic [ColumnW-1:0] column_index, column_index_next;
  sample_t            frame_max, frame_max_next;
  sample_t            frame_min, frame_min_next;
  sample_t            trigger_reg, trigger_reg_next;
  sample_t            previous_sample;
  logic [RunW-1:0]    equal_run, equal_run_next;
  logic               dc_mode, dc_mode_next;
  logic [WaitW-1:0]   wait_count, wait_count_next;

  logic               eq;
  logic               last;
  sample_t            cap_max, cap_min;
  logic [WaitW-1:0]   wait_inc;

  always_comb begin
    phase_next        = phase;
    column_index_next = column_index;
    frame_max_next    = frame_max;
    frame_min_next    = frame_min;
    trigger_reg_next  = trigger_reg;
    equal_run_next    = equal_run;
    dc_mode_next      = dc_mode;
    wait_count_next   = wait_count;

    eq       = (previous_sample == sample);
    last     = (column_index <= ColumnW'(1)) || (column_index > ColTop);
    cap_max  = (sample > frame_max) ? sample : frame_max;
    cap_min  = (sample < frame_min) ? sample : frame_min;
    wait_inc = (wait_count < WaitMax) ? wait_count + WaitW'(1) : wait_count;

    result.produce       = 1'b0;
    result.column        = last ? ColumnW'(1) : column_index;
    result.frame_last    = last;
    result.trigger_level = trigger_reg;

    case (phase)
      PhCapture: begin
        result.produce = 1'b1;
        frame_max_next = cap_max;
        frame_min_next = cap_min;
        if (last) begin
          if (cap_max != cap_min) begin
            trigger_reg_next = sample_t'((cap_max - cap_min) >> 1) + cap_min;
          end
          phase_next     = PhSearch;
          equal_run_next = '0;
        end else begin
          column_index_next = column_index - ColumnW'(1);
        end
        result.trigger_level = trigger_reg_next;
      end
      PhSearch: begin
        if (eq) begin
          equal_run_next = (equal_run < RunMax) ? equal_run + RunW'(1) : equal_run;
          dc_mode_next   = (equal_run_next >= RunLim);
        end
        if (!dc_mode_next && sample == trigger_reg && previous_sample < sample) begin
          phase_next = PhCapture;
        end else if (dc_mode_next && eq && frame_max != frame_min) begin
          phase_next      = PhFall;
          wait_count_next = '0;
        end else if (dc_mode_next && eq) begin
          phase_next = PhCapture;
        end
      end
      PhFall: begin
        wait_count_next = wait_inc;
        if (!(sample > trigger_reg && wait_inc < WaitLim)) begin
          phase_next      = PhRise;
          wait_count_next = '0;
        end
      end
      PhRise: begin
        wait_count_next = wait_inc;
        if (!(sample < trigger_reg && wait_inc < WaitLim)) begin
          phase_next = PhCapture;
        end
      end
      default: begin
        phase_next = PhCapture;
      end
    endcase

    // leaving search for a new frame reloads the column and frame limits
    if (phase != PhCapture && phase_next == PhCapture) begin
      column_index_next = ColTop;
      frame_max_next    = MaxReset;
      frame_min_next    = MinReset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PhCapture;
      column_index    <= ColTop;
      frame_max       <= MaxReset;
      frame_min       <= MinReset;
      trigger_reg     <= TriggerReset;
      previous_sample <= '0;
      equal_run       <= '0;
      dc_mode         <= 1'b0;
      wait_count      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      column_index    <= column_index_next;
      frame_max       <= frame_max_next;
      frame_min       <= frame_min_next;
      trigger_reg     <= trigger_reg_next;
      previous_sample <= sample;
      equal_run       <= equal_run_next;
      dc_mode         <= dc_mode_next;
      wait_count      <= wait_count_next;
    end
  end

endmodule

>>> hw/rtl/scope_capture_and_trigger.sv
// Scope capture and trigger unit.
// Input channel samples: one 8-bit converter sample per beat.
// Output channel points: one display point (column, row, frame_last,
// trigger_level) per sample taken during a capture frame; samples taken
// while searching for a trigger give no beat.
// Configuration: cfg_wr_en / cfg_wr_data write the signed vertical offset;
// the user must do so only while no sample is in flight; not enforced here.
// Throughput: one sample per cycle while the receiver does not stall; each
// sample passes an input register, one pass of row mapping and sequencer
// logic, and the output register.
// When the receiver stalls, the point is held in the output register and
// one more sample can sit in the input register; ready then drops until
// the point is taken.
// Reset: synchronous, clears the offset, starts a capture frame at the top
// column with trigger level 2 and ac search; ready is low during reset.
// depends on sct_pkg, sct_if, sct_row_map, sct_ctrl
module scope_capture_and_trigger
  import sct_pkg::*;
#(
  parameter int FRAME_COLUMNS = FrameColumnsDefault,
  parameter int DC_RUN_LENGTH = DcRunLengthDefault,
  parameter int CROSS_TIMEOUT = CrossTimeoutDefault
) (
  input  logic               clk,
  input  logic               rst,
  sct_sample_if.sink         samples,
  sct_point_if.source        points,
  input  logic               cfg_wr_en,
  input  logic [OffsetW-1:0] cfg_wr_data
);

  logic                      stage_valid;
  sample_t                   stage_sample;
  logic signed [OffsetW-1:0] vertical_offset;
  logic                      advance;
  logic [RowW-1:0]           row;
  sct_result_t               result;

  assign advance       = stage_valid && (!points.valid || points.ready);
  assign samples.ready = !rst && (!stage_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_offset <= '0;
    end else if (cfg_wr_en) begin
      vertical_offset <= $signed(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      stage_sample <= samples.sample;
    end
  end

  sct_row_map u_row_map (
    .sample          (stage_sample),
    .vertical_offset (vertical_offset),
    .row             (row)
  );

  sct_ctrl #(
    .FRAME_COLUMNS (FRAME_COLUMNS),
    .DC_RUN_LENGTH (DC_RUN_LENGTH),
    .CROSS_TIMEOUT (CROSS_TIMEOUT)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (stage_sample),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
    end else if (advance) begin
      points.valid <= result.produce;
    end else if (points.ready) begin
      points.valid <= 1'b0;
    end
  end

  // point payload only moves when a producing beat leaves the input stage
  always_ff @(posedge clk) begin
    if (advance && result.produce) begin
      points.column        <= result.column;
      points.row           <= row;
      points.frame_last    <= result.frame_last;
      points.trigger_level <= result.trigger_level;
    end
  end

endmodule

>>> hw/rtl/sct_checker.sv
// port-level checks of the scope capture and trigger unit, bound to the top level
// depends on sct_pkg, sct_if, scope_capture_and_trigger
module sct_checker
  import sct_pkg::*;
(
  input logic         clk,
  input logic         rst,
  sct_sample_if.sink  samples,
  sct_point_if.source points
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    points.valid && !points.ready |=> points.valid)
    else $error("point beat dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    points.valid && !points.ready |=> $stable(points.column) && $stable(points.row)
      && $stable(points.frame_last) && $stable(points.trigger_level))
    else $error("point payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !points.valid)
    else $error("point beat offered right after reset");

  // checks that every new point follows a sample beat
  a_rise_after_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(points.valid) |-> $past(samples.valid && samples.ready, 2))
    else $error("point beat without a preceding sample beat");

endmodule

bind scope_capture_and_trigger sct_checker u_sct_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples),
  .points  (points)
);
